// File: design/sint_pkg.sv
package sint_pkg;

    // Set store geometry
    localparam int SET_DEPTH = 256;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int KEY_W     = 32;

    // Command codes
    localparam logic [1:0] CMD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_SECOND = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } sint_state_t;

    // Write request into the set store
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic             reported;
    } sint_wr_t;

    // Read data from the set store
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             reported;
    } sint_rd_t;

endpackage

// File: design/set_intersection_unique.sv
// Streaming set intersection with unique results. First-array elements go
// into a set store of SET_DEPTH entries (duplicates ignored, a full store
// drops the element and raises a sticky overflow flag). A second-array
// element that matches a stored, not yet reported entry comes out once.
// End of call returns a final beat with call_finished set and the overflow
// flag, then empties the store. The store is searched linearly through its
// single registered read port, one entry per cycle: an array element keeps
// s_ready low until its search ends, and a match stops the search early.
// End of call keeps s_ready low until its beat enters the output register,
// and an unused command is dropped without any stall. A result also waits
// while an earlier one is still stalled in the output register. Emptying
// the store is a reset of its fill count, so no clearing pass runs after
// reset or at end of call. A finished result waits in the output register
// while the next item is taken.
module set_intersection_unique (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [31:0] s_element_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_common_value,
    output logic               m_call_finished,
    output logic               m_store_overflowed
);
    import sint_pkg::*;

    sint_wr_t         wr;
    sint_rd_t         rd_data;
    logic [IDX_W-1:0] rd_addr;

    sint_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_element_value    (s_element_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_common_value     (m_common_value),
        .m_call_finished    (m_call_finished),
        .m_store_overflowed (m_store_overflowed),
        .wr                 (wr),
        .rd_addr            (rd_addr),
        .rd_data            (rd_data)
    );

    sint_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: design/sint_store.sv
module sint_store (
    input  logic                      aclk,
    input  sint_pkg::sint_wr_t        wr,
    input  logic [sint_pkg::IDX_W-1:0] rd_addr,
    output sint_pkg::sint_rd_t        rd_data
);
    import sint_pkg::*;

    logic [KEY_W-1:0] key_mem [SET_DEPTH];
    logic             rep_mem [SET_DEPTH];
    logic [KEY_W-1:0] rd_key_reg;
    logic             rd_rep_reg;

    // Write key and reported flag together
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            key_mem[wr.addr] <= wr.key;
            rep_mem[wr.addr] <= wr.reported;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_key_reg <= key_mem[rd_addr];
        rd_rep_reg <= rep_mem[rd_addr];
    end

    assign rd_data.key      = rd_key_reg;
    assign rd_data.reported = rd_rep_reg;

endmodule

// File: design/sint_ctrl.sv
module sint_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic signed [31:0]         s_element_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_common_value,
    output logic                       m_call_finished,
    output logic                       m_store_overflowed,
    output sint_pkg::sint_wr_t         wr,
    output logic [sint_pkg::IDX_W-1:0] rd_addr,
    input  sint_pkg::sint_rd_t         rd_data
);
    import sint_pkg::*;

    sint_state_t      state_reg, state_next;
    logic [1:0]       cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic             m_valid_reg;
    logic [KEY_W-1:0] out_value_reg;
    logic             out_fin_reg;
    logic             out_ovf_reg;

    logic accept;
    logic issue;
    logic hit;
    logic miss;
    logic out_free;
    logic load_out;
    logic do_insert;
    logic set_ovf;
    logic clear_store;

    assign accept   = s_valid && s_ready;
    assign issue    = scan_idx_reg < count_reg;
    assign hit      = rd_vld_reg && (rd_data.key == key_reg);
    assign miss     = !hit && !rd_vld_reg && !issue;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_addr  = scan_idx_reg[IDX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_FIRST || s_command == CMD_SECOND) begin
                        state_next = ST_SCAN;
                    end else if (s_command == CMD_END) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (cmd_reg == CMD_SECOND && !rd_data.reported) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (miss) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready     = 1'b0;
        rd_vld_next = 1'b0;
        do_insert   = 1'b0;
        set_ovf     = 1'b0;
        load_out    = 1'b0;
        clear_store = 1'b0;
        wr          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                rd_vld_next = issue && !hit;
                if (cmd_reg == CMD_FIRST && miss) begin
                    if (count_reg < CNT_W'(SET_DEPTH)) begin
                        do_insert   = 1'b1;
                        wr.we       = 1'b1;
                        wr.addr     = count_reg[IDX_W-1:0];
                        wr.key      = key_reg;
                        wr.reported = 1'b0;
                    end else begin
                        set_ovf = 1'b1;
                    end
                end
                if (cmd_reg == CMD_SECOND && hit && !rd_data.reported) begin
                    wr.we       = 1'b1;
                    wr.addr     = rd_idx_reg;
                    wr.key      = key_reg;
                    wr.reported = 1'b1;
                end
            end
            ST_EMIT: begin
                load_out    = out_free;
                clear_store = out_free && (cmd_reg == CMD_END);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            if (accept) begin
                scan_idx_reg <= '0;
            end else if (state_reg == ST_SCAN && issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (clear_store) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                if (do_insert) begin
                    count_reg <= count_reg + 1'b1;
                end
                if (set_ovf) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_command;
            key_reg <= s_element_value;
        end
        rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if (load_out) begin
            out_fin_reg   <= (cmd_reg == CMD_END);
            out_value_reg <= (cmd_reg == CMD_END) ? '0 : key_reg;
            out_ovf_reg   <= (cmd_reg == CMD_END) ? ovf_reg : 1'b0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_common_value     = out_value_reg;
    assign m_call_finished    = out_fin_reg;
    assign m_store_overflowed = out_ovf_reg;

endmodule

// File: design/sint_checker.sv
module sint_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_command,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_common_value,
    input logic               m_call_finished,
    input logic               m_store_overflowed
);
    import sint_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_common_value)
            && $stable(m_call_finished) && $stable(m_store_overflowed))
        else $error("result beat changed while stalled");

    // End-of-call beat carries no element
    a_fin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_call_finished |-> m_common_value == 0)
        else $error("end-of-call beat with nonzero value");

    // Overflow only reported on end-of-call beat
    a_ovf_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_call_finished |-> !m_store_overflowed)
        else $error("overflow flag on common-element beat");

    // End of call occupies the block for its result
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_END |=> !s_ready)
        else $error("ready right after end of call");

endmodule

bind set_intersection_unique sint_checker u_sint_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_command          (s_command),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_common_value     (m_common_value),
    .m_call_finished    (m_call_finished),
    .m_store_overflowed (m_store_overflowed)
);

// File: verif/tb_set_intersection_unique.sv
`timescale 1ns / 100ps

module tb_set_intersection_unique;
    import sint_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 100;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = SET_DEPTH + 16;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    finished;
        logic                    overflowed;
    } match_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] value;
        logic             typed;
        logic             has_result;
        match_t           result;
    } row_t;

    localparam match_t NO_BEAT   = '0;
    localparam match_t CALL_DONE = '{'0, 1'b1, 1'b0};

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_command       = CMD_FIRST;
    logic signed [KEY_W-1:0] s_element_value = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic signed [KEY_W-1:0] m_common_value;
    logic                    m_call_finished;
    logic                    m_store_overflowed;

    // Mirror of the set store
    logic [KEY_W-1:0] set_keys [SET_DEPTH];
    bit               set_reported [SET_DEPTH];
    int               set_fill    = 0;
    bit               set_dropped = 1'b0;

    match_t awaited_q [$];
    int     errors         = 0;
    int     items_sent     = 0;
    int     stalled_cycles = 0;
    bit     in_taken       = 1'b0;

    // Beat currently offered, with its typed-in expectation if any
    bit     row_typed  = 1'b0;
    bit     row_has    = 1'b0;
    match_t row_result = '0;

    // Sender pacing
    int burst_left = 0;
    bit quiet      = 1'b0;

    // Receiver stall pattern
    int          sink_left    = 0;
    int          sink_mode    = 0;
    logic [15:0] sink_pattern = '1;

    row_t directed_rows [0:22] = '{
        '{CMD_END,    32'h0000_0000, 1'b1, 1'b1, CALL_DONE},
        '{CMD_FIRST,  32'h8000_0000, 1'b0, 1'b0, NO_BEAT},
        '{CMD_FIRST,  32'h7fff_ffff, 1'b0, 1'b0, NO_BEAT},
        '{CMD_FIRST,  32'h8000_0000, 1'b0, 1'b0, NO_BEAT},
        '{CMD_FIRST,  32'h0000_0000, 1'b0, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h7fff_ffff, 1'b1, 1'b1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
        '{CMD_SECOND, 32'h7fff_ffff, 1'b1, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h0000_0005, 1'b0, 1'b0, NO_BEAT},
        '{CMD_UNUSED, 32'hffff_ffff, 1'b1, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 1'b0, 1'b0}},
        '{CMD_FIRST,  32'hffff_ffff, 1'b0, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'hffff_ffff, 1'b0, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h0000_0000, 1'b0, 1'b0, NO_BEAT},
        '{CMD_UNUSED, 32'h7fff_ffff, 1'b1, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h8000_0000, 1'b1, 1'b0, NO_BEAT},
        '{CMD_END,    32'hffff_ffff, 1'b1, 1'b1, CALL_DONE},
        '{CMD_SECOND, 32'h7fff_ffff, 1'b1, 1'b0, NO_BEAT},
        '{CMD_END,    32'h0000_0000, 1'b1, 1'b1, CALL_DONE},
        '{CMD_FIRST,  32'h5555_5555, 1'b0, 1'b0, NO_BEAT},
        '{CMD_FIRST,  32'haaaa_aaaa, 1'b0, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'haaaa_aaaa, 1'b0, 1'b0, NO_BEAT},
        '{CMD_SECOND, 32'h5555_5555, 1'b0, 1'b0, NO_BEAT},
        '{CMD_END,    32'h1234_5678, 1'b0, 1'b0, NO_BEAT}
    };

    set_intersection_unique dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_element_value    (s_element_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_common_value     (m_common_value),
        .m_call_finished    (m_call_finished),
        .m_store_overflowed (m_store_overflowed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one input beat to the store mirror; return 1 when it yields a result
    function automatic bit intersect_step(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                          output match_t beat);
        int slot;
        bit hit;
        slot = -1;
        hit  = 1'b0;
        beat = '0;
        for (int i = 0; i < set_fill && slot < 0; i++) begin
            if (set_keys[i] == key) slot = i;
        end
        case (cmd)
            CMD_FIRST: begin
                if (slot < 0) begin
                    if (set_fill < SET_DEPTH) begin
                        set_keys[set_fill]     = key;
                        set_reported[set_fill] = 1'b0;
                        set_fill++;
                    end else begin
                        set_dropped = 1'b1;
                    end
                end
            end
            CMD_SECOND: begin
                if (slot >= 0 && !set_reported[slot]) begin
                    set_reported[slot] = 1'b1;
                    beat.value         = key;
                    hit                = 1'b1;
                end
            end
            CMD_END: begin
                beat.finished   = 1'b1;
                beat.overflowed = set_dropped;
                set_fill        = 0;
                set_dropped     = 1'b0;
                hit             = 1'b1;
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin
        match_t beat;
        match_t want;
        bit     hit;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            hit = intersect_step(s_command, s_element_value, beat);
            if (row_typed) begin
                hit  = row_has;
                beat = row_result;
            end
            if (hit) awaited_q = {awaited_q, beat};
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_q.size() == 0) begin
                $error("result beat with nothing expected: common_value %0d", m_common_value);
                errors++;
            end else begin
                want = awaited_q.pop_front();
                if (m_common_value !== want.value) begin
                    $error("common_value expected %0d got %0d", want.value, m_common_value);
                    errors++;
                end
                if (m_call_finished !== want.finished) begin
                    $error("call_finished expected %0b got %0b", want.finished,
                           m_call_finished);
                    errors++;
                end
                if (m_store_overflowed !== want.overflowed) begin
                    $error("store_overflowed expected %0b got %0b", want.overflowed,
                           m_store_overflowed);
                    errors++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stalled_cycles <= 0;
        else stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the result side, switching at random between modes
    always @(negedge aclk) begin
        if (sink_left == 0) begin
            sink_mode    <= $urandom_range(0, 3);
            sink_pattern <= 16'($urandom);
            sink_left    <= $urandom_range(16, 96);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= sink_pattern[sink_left % 16];
        endcase
    end

    // Offer one beat and hold it until accepted; insert a gap between bursts
    task automatic send(input logic [1:0] cmd, input logic [KEY_W-1:0] value,
                        input bit typed = 1'b0, input bit has = 1'b0,
                        input match_t res = '0);
        if (!quiet && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        row_typed  = typed;
        row_has    = has;
        row_result = res;
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_element_value <= value;
        do @(negedge aclk); while (!in_taken);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // Hold off the sender until every expected result has come out
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (awaited_q.size() != 0);
    endtask

    initial begin
        logic [KEY_W-1:0] pool [10];
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] val;
        logic [1:0]       cmd;
        int               pool_n;
        int               n1;
        int               n2;
        int               goal;

        wait (aresetn);
        @(negedge aclk);

        // Directed rows
        foreach (directed_rows[r]) begin
            send(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].typed,
                 directed_rows[r].has_result, directed_rows[r].result);
        end
        wait_results();

        // Fill the store to the brim: a duplicate while full, then a drop
        base = $urandom;
        for (int i = 0; i < SET_DEPTH; i++) begin
            send(CMD_FIRST, base + i);
            if ($urandom_range(0, 15) == 0) send(CMD_SECOND, base + $urandom_range(0, i));
        end
        send(CMD_FIRST, base + SET_DEPTH - 1);
        send(CMD_FIRST, base + SET_DEPTH);
        send(CMD_FIRST, base);
        send(CMD_SECOND, base + SET_DEPTH);
        send(CMD_SECOND, base + SET_DEPTH - 1);
        send(CMD_END, $urandom);
        wait_results();

        // Random calls: mostly well-formed, with stray commands and missing ends
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            quiet  = ($urandom_range(0, 3) == 0);
            pool_n = $urandom_range(1, 10);
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 11))
                    0:       pool[i] = 32'h8000_0000;
                    1:       pool[i] = 32'h7fff_ffff;
                    2:       pool[i] = 32'hffff_ffff;
                    3:       pool[i] = 32'h0000_0000;
                    default: pool[i] = $urandom;
                endcase
            end
            n1 = $urandom_range(0, 12);
            n2 = $urandom_range(0, 12);
            for (int i = 0; i < n1 + n2; i++) begin
                cmd = (i < n1) ? CMD_FIRST : CMD_SECOND;
                if ($urandom_range(0, 9) == 0) cmd = (cmd == CMD_FIRST) ? CMD_SECOND : CMD_FIRST;
                if ($urandom_range(0, 19) == 0) cmd = CMD_UNUSED;
                if ($urandom_range(0, 3) == 0) val = $urandom;
                else val = pool[$urandom_range(0, pool_n - 1)];
                send(cmd, val);
            end
            if ($urandom_range(0, 9) != 0) send(CMD_END, $urandom);
            if ($urandom_range(0, 7) == 0) wait_results();
        end
        quiet = 1'b0;

        // Drain, then give the block time for any stray beat
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
